/* hw/rtl/cph_pkg.sv */
// ----------------------------------------------------------------------------
// cph_pkg: coincidence pattern histogram shared types and constants
// Word layouts of the input and result channels, item kinds and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package cph_pkg;

  localparam int KIND_W      = 2;
  localparam int CHANNEL_W   = 4;
  localparam int ARRIVAL_W   = 48;
  localparam int BIN_ADDR_W  = 16;
  localparam int BIN_COUNT   = 65536;
  localparam int PATTERN_W   = 16;
  localparam int WINDOW_W    = 16;
  localparam int OUT_COUNT_W = 32;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd30;

  localparam logic [KIND_W-1:0] KIND_PHOTON = 2'd0;
  localparam logic [KIND_W-1:0] KIND_END    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]     kind;
    logic [CHANNEL_W-1:0]  channel;
    logic [ARRIVAL_W-1:0]  arrival_time;
    logic [BIN_ADDR_W-1:0] bin_select;
  } cph_in_t;

  typedef struct packed {
    logic [BIN_ADDR_W-1:0]  bin_index;
    logic [OUT_COUNT_W-1:0] bin_count;
  } cph_out_t;

endpackage

`default_nettype wire

/* hw/rtl/cph_ram.sv */
// ----------------------------------------------------------------------------
// cph_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data <= mem_r[rd_addr];
  end

endmodule

`default_nettype wire

/* hw/rtl/coincidence_pattern_histogram_top.sv */
// ----------------------------------------------------------------------------
// coincidence_pattern_histogram_top: coincidence pattern histogram
// Groups photon events into channel patterns by quantized arrival time and
// keeps a saturating count per pattern in a 65536-bin memory.
//
//   channel  direction  word       handshake
//   in_      input      cph_in_t   in_valid / in_ready
//   out_     output     cph_out_t  out_valid / out_ready
//   cfg_     input      window     cfg_valid / cfg_ready
//
// Photon: window quantization by the one-bit-per-cycle remainder unit, then
//   quantize and compare steps, and a bin update when a pattern closes. End of
//   chunk: resets the open pattern and window start. Read bin: address and data
//   steps, held while an earlier result waits with out_ready low. Clear all
//   bins: one row per cycle; after reset this pass runs before in_ready rises.
// ----------------------------------------------------------------------------
`default_nettype none

module coincidence_pattern_histogram_top #(
  parameter int CHANNELS    = 16,
  parameter int TIME_WIDTH  = 48,
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire cph_pkg::cph_in_t              in_word,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output cph_pkg::cph_out_t                  out_word,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cph_pkg::WINDOW_W-1:0]  cfg_data
);

  localparam int WW    = cph_pkg::WINDOW_W;
  localparam int AW    = cph_pkg::BIN_ADDR_W;
  localparam int PW    = cph_pkg::PATTERN_W;
  localparam int CNT_W = $clog2(TIME_WIDTH);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_QUANT = 3'd3;
  localparam logic [2:0] ST_CMP   = 3'd4;
  localparam logic [2:0] ST_UPD   = 3'd5;
  localparam logic [2:0] ST_RD_A  = 3'd6;
  localparam logic [2:0] ST_RD_D  = 3'd7;

  logic [2:0]                      state_r, state_nxt;
  logic [AW-1:0]                   clr_cnt_r, clr_cnt_nxt;
  logic [WW-1:0]                   window_size_r, window_size_nxt;
  logic [PW-1:0]                   open_pattern_r, open_pattern_nxt;
  logic [TIME_WIDTH-1:0]           wstart_r, wstart_nxt;
  logic                            out_valid_r, out_valid_nxt;
  cph_pkg::cph_out_t               out_word_r, out_word_nxt;

  logic [cph_pkg::KIND_W-1:0]      kind_r, kind_nxt;
  logic [cph_pkg::CHANNEL_W-1:0]   channel_r, channel_nxt;
  logic [AW-1:0]                   sel_r, sel_nxt;
  logic [TIME_WIDTH-1:0]           time_r, time_nxt;
  logic [TIME_WIDTH-1:0]           tsh_r, tsh_nxt;
  logic [WW-1:0]                   rem_r, rem_nxt;
  logic [CNT_W-1:0]                div_cnt_r, div_cnt_nxt;
  logic [TIME_WIDTH-1:0]           q_r, q_nxt;
  logic [TIME_WIDTH-1:0]           next_r, next_nxt;

  logic [WW-1:0]                   win_c;
  logic [WW:0]                     div_trial_c;
  logic [PW-1:0]                   chan_bit_c;
  logic                            in_acc_c;
  logic                            out_free_c;

  logic                            ram_wr_en;
  logic [AW-1:0]                   ram_wr_addr;
  logic [COUNT_WIDTH-1:0]          ram_wr_data;
  logic [AW-1:0]                   ram_rd_addr;
  logic [COUNT_WIDTH-1:0]          ram_rd_data;
  logic [COUNT_WIDTH-1:0]          cnt_inc_c;

  cph_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (cph_pkg::BIN_COUNT)
  ) u_bins (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign in_ready   = (state_r == ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign in_acc_c   = in_valid && in_ready;
  assign out_free_c = !out_valid_r || out_ready;

  assign win_c       = (window_size_r == '0) ? WW'(1) : window_size_r;
  assign div_trial_c = {rem_r, tsh_r[TIME_WIDTH-1]};
  assign chan_bit_c  = PW'(1) << channel_r;
  assign ram_rd_addr = (kind_r == cph_pkg::KIND_READ) ? sel_r : open_pattern_r;
  assign cnt_inc_c   = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_WIDTH'(1);

  always_comb begin
    state_nxt        = state_r;
    clr_cnt_nxt      = clr_cnt_r;
    window_size_nxt  = window_size_r;
    open_pattern_nxt = open_pattern_r;
    wstart_nxt       = wstart_r;
    out_valid_nxt    = out_valid_r;
    out_word_nxt     = out_word_r;
    kind_nxt         = kind_r;
    channel_nxt      = channel_r;
    sel_nxt          = sel_r;
    time_nxt         = time_r;
    tsh_nxt          = tsh_r;
    rem_nxt          = rem_r;
    div_cnt_nxt      = div_cnt_r;
    q_nxt            = q_r;
    next_nxt         = next_r;
    ram_wr_en        = 1'b0;
    ram_wr_addr      = open_pattern_r;
    ram_wr_data      = cnt_inc_c;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cfg_valid && cfg_ready) begin
      window_size_nxt = cfg_data;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_cnt_r;
        ram_wr_data = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc_c) begin
          kind_nxt    = in_word.kind;
          channel_nxt = in_word.channel;
          sel_nxt     = in_word.bin_select;
          time_nxt    = TIME_WIDTH'(in_word.arrival_time);
          tsh_nxt     = TIME_WIDTH'(in_word.arrival_time);
          rem_nxt     = '0;
          div_cnt_nxt = CNT_W'(TIME_WIDTH - 1);
          unique case (in_word.kind)
            cph_pkg::KIND_PHOTON: begin
              if (int'(in_word.channel) < CHANNELS) begin
                state_nxt = ST_DIV;
              end
            end
            cph_pkg::KIND_END: begin
              open_pattern_nxt = '0;
              wstart_nxt       = '0;
            end
            cph_pkg::KIND_READ: begin
              state_nxt = ST_RD_A;
            end
            cph_pkg::KIND_CLEAR: begin
              clr_cnt_nxt = '0;
              state_nxt   = ST_CLR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_trial_c >= {1'b0, win_c}) begin
          rem_nxt = WW'(div_trial_c - {1'b0, win_c});
        end else begin
          rem_nxt = div_trial_c[WW-1:0];
        end
        tsh_nxt     = tsh_r << 1;
        div_cnt_nxt = div_cnt_r - CNT_W'(1);
        if (div_cnt_r == '0) begin
          state_nxt = ST_QUANT;
        end
      end
      ST_QUANT: begin
        q_nxt     = time_r - TIME_WIDTH'(rem_r);
        next_nxt  = wstart_r + TIME_WIDTH'(win_c);
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (q_r == wstart_r || q_r == next_r) begin
          open_pattern_nxt = open_pattern_r | chan_bit_c;
          wstart_nxt       = q_r;
          state_nxt        = ST_IDLE;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        ram_wr_en        = 1'b1;
        open_pattern_nxt = chan_bit_c;
        wstart_nxt       = q_r;
        state_nxt        = ST_IDLE;
      end
      ST_RD_A: begin
        state_nxt = ST_RD_D;
      end
      ST_RD_D: begin
        if (out_free_c) begin
          out_valid_nxt          = 1'b1;
          out_word_nxt.bin_index = sel_r;
          out_word_nxt.bin_count = cph_pkg::OUT_COUNT_W'(ram_rd_data);
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLR;
      clr_cnt_r      <= '0;
      window_size_r  <= cph_pkg::WINDOW_RESET;
      open_pattern_r <= '0;
      wstart_r       <= '0;
      out_valid_r    <= 1'b0;
      kind_r         <= cph_pkg::KIND_PHOTON;
    end else begin
      state_r        <= state_nxt;
      clr_cnt_r      <= clr_cnt_nxt;
      window_size_r  <= window_size_nxt;
      open_pattern_r <= open_pattern_nxt;
      wstart_r       <= wstart_nxt;
      out_valid_r    <= out_valid_nxt;
      kind_r         <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
    channel_r  <= channel_nxt;
    sel_r      <= sel_nxt;
    time_r     <= time_nxt;
    tsh_r      <= tsh_nxt;
    rem_r      <= rem_nxt;
    div_cnt_r  <= div_cnt_nxt;
    q_r        <= q_nxt;
    next_r     <= next_nxt;
  end

  a_rem_below_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV || state_r == ST_QUANT) |-> (rem_r < win_c))
    else $error("remainder not below window");

  a_update_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (ram_wr_en && ram_wr_data != '0))
    else $error("bin update wrote zero");

  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RD_D))
    else $error("result word without bin read");

  a_quant_multiple: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> (q_r <= time_r))
    else $error("quantized time above arrival time");

endmodule

`default_nettype wire

/* verif/tb_coincidence_pattern_histogram_top.sv */
// ----------------------------------------------------------------------------
// tb_coincidence_pattern_histogram_top: coincidence pattern histogram bench
// Runs a short scripted sequence, then random photon bursts, reads, chunk ends
// and clears under several window settings with random idling on both sides.
// An in-bench histogram model predicts each read, except script rows that
// carry their own expected result; results are checked in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_coincidence_pattern_histogram_top;

  localparam int CHANNELS    = 16;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 64;

  localparam int KND_W = cph_pkg::KIND_W;
  localparam int CH_W  = cph_pkg::CHANNEL_W;
  localparam int AT_W  = cph_pkg::ARRIVAL_W;
  localparam int AD_W  = cph_pkg::BIN_ADDR_W;
  localparam int PAT_W = cph_pkg::PATTERN_W;
  localparam int WIN_W = cph_pkg::WINDOW_W;
  localparam int OC_W  = cph_pkg::OUT_COUNT_W;

  typedef struct {
    cph_pkg::cph_in_t  w;
    bit                typed;
    cph_pkg::cph_out_t res;
  } script_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  cph_pkg::cph_in_t  in_word = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  cph_pkg::cph_out_t out_word;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [WIN_W-1:0]  cfg_data = '0;

  // histogram model
  logic [WIN_W-1:0] window_reg;
  logic [PAT_W-1:0] open_pat;
  logic [AT_W-1:0]  open_start;
  logic [OC_W-1:0]  tally [logic [AD_W-1:0]];
  logic [AD_W-1:0]  last_stored;

  cph_pkg::cph_out_t pending_reads [$];
  int                fail_count = 0;
  bit                no_idle = 1'b0;
  bit                hold_request = 1'b0;
  int                hold_left = 0;
  int                clears_left = 2;
  logic [AT_W-1:0]   stream_t = '0;

  coincidence_pattern_histogram_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [OC_W-1:0] bin_value(input logic [AD_W-1:0] b);
    return tally.exists(b) ? tally[b] : '0;
  endfunction

  function automatic bit histogram_step(input cph_pkg::cph_in_t w,
                                        output cph_pkg::cph_out_t res);
    logic [AT_W-1:0] win;
    logic [AT_W-1:0] q;
    logic [AT_W-1:0] nxt;
    logic [OC_W-1:0] cur;
    res = '0;
    case (w.kind)
      cph_pkg::KIND_PHOTON: begin
        if (int'(w.channel) < CHANNELS) begin
          win = (window_reg == '0) ? AT_W'(1) : AT_W'(window_reg);
          q = w.arrival_time - (w.arrival_time % win);
          nxt = open_start + win;
          if (q == open_start || q == nxt) begin
            open_pat = open_pat | (PAT_W'(1) << w.channel);
          end else begin
            cur = bin_value(open_pat);
            if (cur != '1) tally[open_pat] = cur + OC_W'(1);
            last_stored = open_pat;
            open_pat = PAT_W'(1) << w.channel;
          end
          open_start = q;
        end
        return 1'b0;
      end
      cph_pkg::KIND_END: begin
        open_pat = '0;
        open_start = '0;
        return 1'b0;
      end
      cph_pkg::KIND_READ: begin
        res.bin_index = w.bin_select;
        res.bin_count = bin_value(w.bin_select);
        return 1'b1;
      end
      default: begin
        tally.delete();
        return 1'b0;
      end
    endcase
  endfunction

  function automatic logic [AT_W-1:0] rand48();
    return AT_W'({$urandom, $urandom});
  endfunction

  function automatic cph_pkg::cph_in_t rand_word();
    cph_pkg::cph_in_t w;
    w.kind = KND_W'($urandom_range(3));
    w.channel = CH_W'($urandom_range(15));
    w.arrival_time = rand48();
    w.bin_select = AD_W'($urandom_range(16'hFFFF));
    return w;
  endfunction

  function automatic logic [AT_W-1:0] time_step();
    int unsigned win;
    int unsigned pick;
    win = (window_reg == '0) ? 1 : int'(window_reg);
    pick = $urandom_range(99);
    if (pick < 25) return '0;
    if (pick < 85) return AT_W'($urandom_range(2 * win));
    return rand48() >> $urandom_range(47, 8);
  endfunction

  function automatic logic [AD_W-1:0] pick_bin();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 50) return last_stored;
    if (pick < 60) return '0;
    if (pick < 65) return '1;
    if (pick < 75) return open_pat;
    return AD_W'($urandom_range(16'hFFFF));
  endfunction

  task automatic send_word(input cph_pkg::cph_in_t w, input bit typed,
                           input cph_pkg::cph_out_t typed_res);
    cph_pkg::cph_out_t res;
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (histogram_step(w, res)) pending_reads.push_back(typed ? typed_res : res);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reads.size() != 0) @(posedge clk);
  endtask

  task automatic load_window(input logic [WIN_W-1:0] v);
    drain();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    window_reg = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_read(input logic [AD_W-1:0] b);
    cph_pkg::cph_in_t w;
    w = rand_word();
    w.kind = cph_pkg::KIND_READ;
    w.bin_select = b;
    send_word(w, 1'b0, '0);
  endtask

  task automatic run_phase(input int n);
    int               sent;
    int unsigned      pick;
    int unsigned      win;
    int               burst;
    cph_pkg::cph_in_t w;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(99);
      win = (window_reg == '0) ? 1 : int'(window_reg);
      w = rand_word();
      if (pick < 60) begin
        burst = $urandom_range(1, 8);
        repeat (burst) begin
          stream_t = stream_t + time_step();
          w = rand_word();
          w.kind = cph_pkg::KIND_PHOTON;
          w.arrival_time = stream_t;
          send_word(w, 1'b0, '0);
          sent++;
        end
      end else if (pick < 75) begin
        send_read(pick_bin());
        sent++;
      end else if (pick < 79) begin
        w.kind = cph_pkg::KIND_END;
        send_word(w, 1'b0, '0);
        sent++;
        if ($urandom_range(1) == 0) stream_t = AT_W'($urandom_range(99));
      end else if (pick < 83) begin
        w.kind = cph_pkg::KIND_PHOTON;
        send_word(w, 1'b0, '0);
        sent++;
      end else if (pick < 86) begin
        // jump near the top of the time range so the window sum wraps
        stream_t = '1 - AT_W'($urandom_range(3 * win));
      end else if (pick < 87 && clears_left > 0) begin
        w.kind = cph_pkg::KIND_CLEAR;
        send_word(w, 1'b0, '0);
        clears_left--;
        sent++;
      end else begin
        stream_t = stream_t + time_step();
        w.kind = cph_pkg::KIND_PHOTON;
        w.arrival_time = stream_t;
        send_word(w, 1'b0, '0);
        sent++;
      end
    end
    send_read(pick_bin());
  endtask

  always @(negedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    cph_pkg::cph_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reads.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected read result: bin %h count %h",
                   out_word.bin_index, out_word.bin_count);
      end else begin
        want = pending_reads.pop_front();
        if (want.bin_index != out_word.bin_index || want.bin_count != out_word.bin_count) begin
          fail_count++;
          if (fail_count <= 10)
            $display("read mismatch: expected bin %h count %h, got bin %h count %h",
                     want.bin_index, want.bin_count, out_word.bin_index, out_word.bin_count);
        end
      end
    end
  end

  initial begin
    script_row_t      script [22];
    logic [WIN_W-1:0] settings [6];
    logic [AT_W-1:0]  tmax;
    tmax = '1;
    script = '{
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0000}, 1'b1, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd15, tmax,    16'hFFFF}, 1'b1, '{16'hFFFF, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd0,  48'd100, 16'hFFFF}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd15, 48'd119, 16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd3,  48'd120, 16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd7,  48'd300, 16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h8009}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_END,    4'd0,  48'd0,   16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd2,  48'd0,   16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd9,  48'd31,  16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_END,    4'd15, tmax,    16'hFFFF}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0204}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd0,  tmax,    16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd1,  tmax,    16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd4,  48'd14,  16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_CLEAR,  4'd15, tmax,    16'hFFFF}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0000}, 1'b1, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0003}, 1'b1, '{16'h0003, 32'd0}},
      '{'{cph_pkg::KIND_PHOTON, 4'd6,  48'd400, 16'h0000}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0010}, 1'b0, '{16'h0000, 32'd0}},
      '{'{cph_pkg::KIND_READ,   4'd0,  48'd0,   16'h0001}, 1'b0, '{16'h0000, 32'd0}}
    };
    settings = '{16'd1, 16'hFFFF, 16'd0, 16'($urandom_range(2, 100)),
                 16'($urandom_range(1, 16'hFFFF)), cph_pkg::WINDOW_RESET};

    window_reg = cph_pkg::WINDOW_RESET;
    open_pat = '0;
    open_start = '0;
    last_stored = '0;
    tally.delete();

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) send_word(script[i].w, script[i].typed, script[i].res);

    foreach (settings[p]) begin
      load_window(settings[p]);
      stream_t = '0;
      no_idle = (p == 0);
      if (p == 1) begin
        run_phase(30);
        // stall the result side while reads keep coming
        hold_request = 1'b1;
        repeat (12) send_read(pick_bin());
        run_phase(33);
      end else if (p == 3) begin
        run_phase(30);
        drain();
        run_phase(33);
      end else begin
        run_phase(63);
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending_reads.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/cph_pkg.sv
hw/rtl/cph_ram.sv
hw/rtl/coincidence_pattern_histogram_top.sv
verif/tb_coincidence_pattern_histogram_top.sv
